>>> rtl/core/slot_table_alloc_lookup_macros.svh
// Assertion helpers shared by the slot table design.
`ifndef SLOT_TABLE_ALLOC_LOOKUP_MACROS_SVH
`define SLOT_TABLE_ALLOC_LOOKUP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define STAL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define STAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/stal_pkg.sv
package stal_pkg;

  localparam int SHELVES    = 4;
  localparam int ROWS       = 4;
  localparam int COLS       = 4;
  localparam int SLOT_COUNT = SHELVES * ROWS * COLS;
  localparam int STEP_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam int CODE_W   = 32;
  localparam int POS_W    = 2;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_READ   = 2'd2,
    OP_REMOVE = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_BAD       = 3'd4
  } status_e;

  // Contents of one slot as it travels around the ring.
  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
  } slot_t;

endpackage

>>> rtl/core/stal_cell.sv
module stal_cell
  import stal_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,
  input  slot_t slot_i,
  output slot_t slot_o
);

  slot_t slot_q;

  // Each cell takes its neighbor's slot whenever the ring advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (shift_i) begin
      slot_q <= slot_i;
    end
  end

  assign slot_o = slot_q;

endmodule

>>> rtl/core/slot_table_alloc_lookup.sv
// Slot table with insert, find by code, read by position and remove by position.
// Commands arrive as beats on the s_axis channel and each one produces exactly
// one result beat on the m_axis channel.
// The slots live in a ring of identical cells. For each command the ring turns
// once all the way round, one slot per cycle, and the controller looks at the
// head cell as each slot passes it, in shelf-row-column order. A slot that is
// filled or cleared is rewritten as it leaves the head, so after a full turn
// every slot is back in its home cell.
// A new command is accepted only while the controller is idle, never while
// the ring is turning or a finished result still waits for the output register.
// The finished result waits in an output register, so a new command is taken
// while an earlier result is still waiting on a stalled receiver. A second
// finished result holds in the controller until that register frees up.
// Reset empties every slot and every code at once; no sweep is needed and the
// block is ready for a command as soon as reset is released.
// Out-of-range positions and a zero find code return the bad position status.
module slot_table_alloc_lookup
  import stal_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0 up: opcode[1:0], item_code[33:2], shelf[35:34],
  // row[37:36], column[39:38].
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0 up: status[2:0], found_shelf[4:3], found_row[6:5],
  // found_column[8:7], found_code[40:9], occupied[41], zero fill[47:42].
  output logic [47:0] m_axis_tdata
);

  `include "slot_table_alloc_lookup_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e state_q;

  // Latched command.
  op_e               op_q;
  logic [CODE_W-1:0] code_q;
  logic [POS_W-1:0]  sh_q, row_q, col_q;
  logic              pos_ok_q;

  // Scan position of the slot currently at the head of the ring.
  logic [STEP_W-1:0] step_q;
  logic [POS_W-1:0]  sc_sh_q, sc_row_q, sc_col_q;

  // What the scan found.
  logic              hit_q;
  logic [POS_W-1:0]  hit_sh_q, hit_row_q, hit_col_q;
  logic              hvalid_q;
  logic [CODE_W-1:0] hcode_q;

  // Output register.
  logic              out_valid_q;
  logic [47:0]       out_data_q;

  // Ring of cells; cell 0 is the head that the controller watches.
  slot_t ring[SLOT_COUNT];
  slot_t head_new;
  logic  shift;

  assign shift = (state_q == S_SCAN);

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_ring
    slot_t cell_in;
    if (i == SLOT_COUNT - 1) begin : g_tail
      assign cell_in = head_new;
    end else begin : g_link
      assign cell_in = ring[i+1];
    end
    stal_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .slot_i (cell_in),
      .slot_o (ring[i])
    );
  end

  logic in_acc;
  logic out_load;
  logic at_target;
  logic hit_now;
  logic pos_ok_in;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);
  assign at_target     = (sc_sh_q == sh_q) && (sc_row_q == row_q) && (sc_col_q == col_q);

  assign pos_ok_in = (int'(s_axis_tdata[35:34]) < SHELVES) &&
                     (int'(s_axis_tdata[37:36]) < ROWS) &&
                     (int'(s_axis_tdata[39:38]) < COLS);

  // Decide what the head slot becomes and whether this slot is the one hit.
  always_comb begin
    head_new = ring[0];
    hit_now  = 1'b0;
    case (op_q)
      OP_INSERT: begin
        if (!hit_q && !ring[0].valid) begin
          hit_now        = 1'b1;
          head_new.valid = 1'b1;
          head_new.code  = code_q;
        end
      end
      OP_FIND: begin
        if (!hit_q && (code_q != '0) && ring[0].valid && (ring[0].code == code_q)) begin
          hit_now = 1'b1;
        end
      end
      OP_READ: begin
        if (pos_ok_q && at_target) begin
          hit_now = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos_ok_q && at_target) begin
          hit_now  = 1'b1;
          head_new = '0;
        end
      end
      default: begin
        hit_now = 1'b0;
      end
    endcase
  end

  // Result assembled from what the scan recorded.
  status_e           res_status;
  logic [POS_W-1:0]  res_sh, res_row, res_col;
  logic [CODE_W-1:0] res_code;
  logic              res_occ;

  always_comb begin
    res_status = ST_OK;
    res_sh     = '0;
    res_row    = '0;
    res_col    = '0;
    res_code   = '0;
    res_occ    = 1'b0;
    case (op_q)
      OP_INSERT: begin
        if (hit_q) begin
          res_sh   = hit_sh_q;
          res_row  = hit_row_q;
          res_col  = hit_col_q;
          res_code = code_q;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_FIND: begin
        if (code_q == '0) begin
          res_status = ST_BAD;
        end else if (hit_q) begin
          res_sh   = hit_sh_q;
          res_row  = hit_row_q;
          res_col  = hit_col_q;
          res_code = code_q;
          res_occ  = 1'b1;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      OP_READ, OP_REMOVE: begin
        if (!pos_ok_q) begin
          res_status = ST_BAD;
        end else begin
          res_sh  = sh_q;
          res_row = row_q;
          res_col = col_q;
          if (hvalid_q) begin
            res_code = hcode_q;
            res_occ  = 1'b1;
          end else begin
            res_status = ST_EMPTY;
          end
        end
      end
      default: begin
        res_status = ST_BAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      op_q        <= OP_INSERT;
      code_q      <= '0;
      sh_q        <= '0;
      row_q       <= '0;
      col_q       <= '0;
      pos_ok_q    <= 1'b0;
      hit_q       <= 1'b0;
      hit_sh_q    <= '0;
      hit_row_q   <= '0;
      hit_col_q   <= '0;
      hvalid_q    <= 1'b0;
      hcode_q     <= '0;
      step_q      <= '0;
      sc_sh_q     <= '0;
      sc_row_q    <= '0;
      sc_col_q    <= '0;
    end else begin
      // The output register loads a finished result, or empties once taken.
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_data_q  <= {6'b0, res_occ, res_code, res_col, res_row, res_sh, res_status};
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            op_q     <= op_e'(s_axis_tdata[1:0]);
            code_q   <= s_axis_tdata[33:2];
            sh_q     <= s_axis_tdata[35:34];
            row_q    <= s_axis_tdata[37:36];
            col_q    <= s_axis_tdata[39:38];
            pos_ok_q <= pos_ok_in;
            hit_q    <= 1'b0;
            hvalid_q <= 1'b0;
            hcode_q  <= '0;
            step_q   <= '0;
            sc_sh_q  <= '0;
            sc_row_q <= '0;
            sc_col_q <= '0;
            state_q  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit_now) begin
            hit_q     <= 1'b1;
            hit_sh_q  <= sc_sh_q;
            hit_row_q <= sc_row_q;
            hit_col_q <= sc_col_q;
            hvalid_q  <= ring[0].valid;
            hcode_q   <= ring[0].code;
          end
          // Column runs fastest, shelf slowest.
          if (sc_col_q == POS_W'(COLS - 1)) begin
            sc_col_q <= '0;
            if (sc_row_q == POS_W'(ROWS - 1)) begin
              sc_row_q <= '0;
              sc_sh_q  <= sc_sh_q + 1'b1;
            end else begin
              sc_row_q <= sc_row_q + 1'b1;
            end
          end else begin
            sc_col_q <= sc_col_q + 1'b1;
          end
          if (step_q == STEP_W'(SLOT_COUNT - 1)) begin
            state_q <= S_DONE;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `STAL_ASSERT_NEXT(a_scan_starts, in_acc, (state_q == S_SCAN) && (step_q == '0),
                    "accepted command did not start a scan at the first slot")
  `STAL_ASSERT_IMPL(a_no_accept_in_scan, state_q == S_SCAN, !s_axis_tready,
                    "command accepted while the ring is turning")
  `STAL_ASSERT_IMPL(a_result_after_scan, $rose(m_axis_tvalid), $past(state_q == S_DONE),
                    "result offered without a finished scan")

endmodule

>>> dv/slot_table_checker.sv
module slot_table_checker
  import stal_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  // Fields from bit 0 up: opcode, item_code, shelf, row, column.
  input  logic [39:0] s_axis_tdata_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  // Fields from bit 0 up: status, found_shelf, found_row, found_column,
  // found_code, occupied, zero fill.
  input  logic [47:0] m_axis_tdata_i,
  output int          results_seen_o,
  output int          fail_cnt_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e           status;
    logic [POS_W-1:0]  shelf;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  column;
    logic [CODE_W-1:0] code;
    logic              occupied;
  } slot_result_t;

  logic              slot_used [SLOT_COUNT];
  logic [CODE_W-1:0] slot_code [SLOT_COUNT];
  slot_result_t      pending_results [$];
  slot_result_t      want;
  int                errors;

  function automatic slot_result_t at_slot(status_e st, int idx, logic [CODE_W-1:0] code,
                                           logic occ);
    slot_result_t res;
    res.status   = st;
    res.shelf    = POS_W'(idx / (ROWS * COLS));
    res.row      = POS_W'((idx / COLS) % ROWS);
    res.column   = POS_W'(idx % COLS);
    res.code     = code;
    res.occupied = occ;
    return res;
  endfunction

  // Applies one command to the shadow table and returns the result it must produce.
  function automatic slot_result_t predict_slot_op(logic [39:0] beat);
    op_e               op;
    logic [CODE_W-1:0] code;
    int                s, r, c, idx;
    logic              done;
    slot_result_t      res;
    op   = op_e'(beat[1:0]);
    code = beat[33:2];
    s    = int'(beat[35:34]);
    r    = int'(beat[37:36]);
    c    = int'(beat[39:38]);
    done = 1'b0;
    res  = '0;
    case (op)
      OP_INSERT: begin
        res.status = ST_FULL;
        for (idx = 0; idx < SLOT_COUNT; idx++) begin
          if (!done && !slot_used[idx]) begin
            slot_used[idx] = 1'b1;
            slot_code[idx] = code;
            res  = at_slot(ST_OK, idx, code, 1'b0);
            done = 1'b1;
          end
        end
      end
      OP_FIND: begin
        if (code == '0) begin
          res.status = ST_BAD;
        end else begin
          res.status = ST_NOT_FOUND;
          for (idx = 0; idx < SLOT_COUNT; idx++) begin
            if (!done && slot_used[idx] && slot_code[idx] == code) begin
              res  = at_slot(ST_OK, idx, code, 1'b1);
              done = 1'b1;
            end
          end
        end
      end
      default: begin
        if (s >= SHELVES || r >= ROWS || c >= COLS) begin
          res.status = ST_BAD;
        end else begin
          idx = (s * ROWS + r) * COLS + c;
          if (!slot_used[idx]) begin
            res = at_slot(ST_EMPTY, idx, '0, 1'b0);
          end else begin
            res = at_slot(ST_OK, idx, slot_code[idx], 1'b1);
            if (op == OP_REMOVE) begin
              slot_used[idx] = 1'b0;
              slot_code[idx] = '0;
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic int check_field(string name, logic [CODE_W-1:0] exp_val,
                                     logic [CODE_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_used[i] = 1'b0;
        slot_code[i] = '0;
      end
      pending_results.delete();
      errors = 0;
      results_seen_o <= 0;
      fail_cnt_o     <= 0;
    end else begin
      // Result side first, so a beat that shows up too early is not matched
      // against a command accepted on the same edge.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        results_seen_o <= results_seen_o + 1;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %0h", $time,
                   m_axis_tdata_i);
          errors++;
        end else begin
          want = pending_results.pop_front();
          errors += check_field("status", CODE_W'(want.status), CODE_W'(m_axis_tdata_i[2:0]));
          errors += check_field("found_shelf", CODE_W'(want.shelf), CODE_W'(m_axis_tdata_i[4:3]));
          errors += check_field("found_row", CODE_W'(want.row), CODE_W'(m_axis_tdata_i[6:5]));
          errors += check_field("found_column", CODE_W'(want.column),
                                CODE_W'(m_axis_tdata_i[8:7]));
          errors += check_field("found_code", want.code, m_axis_tdata_i[40:9]);
          errors += check_field("occupied", CODE_W'(want.occupied), CODE_W'(m_axis_tdata_i[41]));
          errors += check_field("zero fill", '0, CODE_W'(m_axis_tdata_i[47:42]));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        pending_results.push_back(predict_slot_op(s_axis_tdata_i));
      end
      fail_cnt_o <= errors + pending_results.size();
    end
  end

endmodule

>>> dv/slot_table_alloc_lookup_tb.sv
module slot_table_alloc_lookup_tb
  import stal_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Cap on the run. The slowest correct run is roughly 825 commands, each with a
  // full ring turn, the longest sender gap and the longest receiver stall; the
  // cap is several times that long.
  localparam int CYCLE_LIMIT = 500000;
  // Settle time after the last result, longer than one command takes to finish.
  localparam int TAIL_CYCLES = 80;
  localparam int PHASE_ITEMS = 100;
  localparam int PHASES      = 8;

  // The random part runs in phases. Filling phases are insert-heavy so the
  // table runs full, draining phases are remove-heavy so it empties again.
  typedef enum logic [1:0] {
    PH_FILL,
    PH_MIX,
    PH_DRAIN
  } phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // Fields from bit 0 up: opcode[1:0], item_code[33:2], shelf[35:34],
  // row[37:36], column[39:38].
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // Fields from bit 0 up: status[2:0], found_shelf[4:3], found_row[6:5],
  // found_column[8:7], found_code[40:9], occupied[41], zero fill[47:42].
  logic [47:0] m_axis_tdata;

  int          results_seen;
  int          fail_cnt;
  int          cmds_sent = 0;
  int          cycle_cnt = 0;
  int          stall_left = 0;
  logic        quiet = 1'b0;
  logic [CODE_W-1:0] code_pool [12];

  always #6 clk_i = ~clk_i;

  slot_table_alloc_lookup dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  slot_table_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .results_seen_o  (results_seen),
    .fail_cnt_o      (fail_cnt)
  );

  // Watchdog. A hung handshake or a lost result ends up here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result receiver. It drops tready for bursts of random length at random,
  // and stays ready throughout the quiet tail of the run.
  always @(posedge clk_i) begin
    if (!quiet && stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left    <= $urandom_range(0, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [39:0] pack_cmd(op_e op, logic [CODE_W-1:0] code,
                                           logic [POS_W-1:0] s, logic [POS_W-1:0] r,
                                           logic [POS_W-1:0] c);
    return {c, r, s, code, op};
  endfunction

  // Offers one command beat and holds it until the block takes it. The call
  // returns on the accepting edge, so a following call keeps tvalid high
  // without a gap.
  task automatic send_cmd(logic [39:0] beat);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= beat;
    do @(posedge clk_i); while (!s_axis_tready);
    cmds_sent++;
  endtask

  // Sender gap of random length, now and then, except in the quiet tail.
  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  // Holds off new commands until every result in flight has been taken.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (results_seen != cmds_sent) @(posedge clk_i);
  endtask

  // Codes are mostly drawn from a small pool, so finds hit and duplicates
  // occur, with some fully random and some zero codes mixed in.
  function automatic logic [CODE_W-1:0] pick_code();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return '0;
    if (roll < 20) return $urandom;
    return code_pool[$urandom_range(0, 11)];
  endfunction

  function automatic op_e pick_op(phase_e ph);
    int roll;
    roll = $urandom_range(0, 99);
    case (ph)
      PH_FILL: begin
        if (roll < 65) return OP_INSERT;
        if (roll < 85) return OP_FIND;
        if (roll < 93) return OP_READ;
        return OP_REMOVE;
      end
      PH_DRAIN: begin
        if (roll < 10) return OP_INSERT;
        if (roll < 30) return OP_FIND;
        if (roll < 50) return OP_READ;
        return OP_REMOVE;
      end
      default: return op_e'($urandom_range(0, 3));
    endcase
  endfunction

  initial begin
    phase_e ph;

    code_pool[0] = 32'h0000_0001;
    code_pool[1] = 32'hFFFF_FFFF;
    code_pool[2] = 32'h8000_0000;
    code_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < 12; i++) code_pool[i] = $urandom;

    // Reset is held low from the start and released on a rising edge.
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Reads and removes of an empty table, a zero find code,
    // a code that is absent, extreme codes, a zero code stored on insert,
    // duplicate codes where find must return the first one, and reuse of a
    // freed slot by the next insert.
    send_cmd(pack_cmd(OP_READ,   '0,           2'd0, 2'd0, 2'd0));
    send_cmd(pack_cmd(OP_REMOVE, 32'hFFFF_FFFF, 2'd3, 2'd3, 2'd3));
    send_cmd(pack_cmd(OP_FIND,   '0,           2'd0, 2'd0, 2'd0));
    send_cmd(pack_cmd(OP_FIND,   32'h1234_5678, 2'd0, 2'd0, 2'd0));
    send_cmd(pack_cmd(OP_INSERT, 32'hFFFF_FFFF, 2'd3, 2'd3, 2'd3));
    send_cmd(pack_cmd(OP_INSERT, '0,           2'd0, 2'd0, 2'd0));
    send_cmd(pack_cmd(OP_INSERT, 32'h8000_0000, 2'd0, 2'd0, 2'd0));
    send_cmd(pack_cmd(OP_INSERT, 32'hFFFF_FFFF, 2'd0, 2'd0, 2'd0));
    send_cmd(pack_cmd(OP_FIND,   32'hFFFF_FFFF, 2'd0, 2'd0, 2'd0));
    send_cmd(pack_cmd(OP_FIND,   32'h8000_0000, 2'd3, 2'd3, 2'd3));
    send_cmd(pack_cmd(OP_READ,   32'hFFFF_FFFF, 2'd0, 2'd0, 2'd1));
    send_cmd(pack_cmd(OP_REMOVE, '0,           2'd0, 2'd0, 2'd0));
    send_cmd(pack_cmd(OP_REMOVE, '0,           2'd0, 2'd0, 2'd0));
    send_cmd(pack_cmd(OP_FIND,   32'hFFFF_FFFF, 2'd0, 2'd0, 2'd0));
    send_cmd(pack_cmd(OP_INSERT, 32'h0000_0001, 2'd0, 2'd0, 2'd0));
    send_cmd(pack_cmd(OP_READ,   32'hFFFF_FFFF, 2'd3, 2'd3, 2'd3));
    send_cmd(pack_cmd(OP_READ,   '0,           2'd2, 2'd1, 2'd3));
    send_cmd(pack_cmd(OP_READ,   '0,           2'd0, 2'd0, 2'd0));

    // The sender stops here until every directed result has come back.
    drain_results();

    // Random part. The last phase runs with no idling on either side.
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: ph = PH_FILL;
        1: ph = PH_MIX;
        2: ph = PH_FILL;
        default: ph = PH_DRAIN;
      endcase
      if (p == PHASES - 1) begin
        drain_results();
        quiet <= 1'b1;
        ph = PH_MIX;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        maybe_gap();
        send_cmd(pack_cmd(pick_op(ph), pick_code(), POS_W'($urandom), POS_W'($urandom),
                          POS_W'($urandom)));
      end
    end

    // Wait for the last results, then let the block settle before the verdict.
    s_axis_tvalid <= 1'b0;
    while (results_seen != cmds_sent) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
